FILE: hdl/bpfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpfe_pkg;

    // input command codes
    localparam logic CMD_PLANE = 1'b0;
    localparam logic CMD_END   = 1'b1;

    // outcome codes
    localparam logic [1:0] OC_DRAW = 2'b00;
    localparam logic [1:0] OC_WIN  = 2'b01;

    localparam int unsigned NUM_PLANES  = 12;
    localparam logic [9:0]  PAD_INDEX   = 10'd768;
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam int signed   SCORE_LIMIT = 8191;
    localparam int unsigned EXP_STEPS   = 13;
    localparam int unsigned QUOT_BITS   = 17;
    // exp(-1/400) in q0.32
    localparam logic [31:0] EXP_STEP_Q32 = 32'd4284243288;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic pcnt;
        logic feat;
        logic exp_step;
        logic div_init;
        logic div_step;
        logic mix1;
        logic mix2;
        logic pad;
        logic tgt;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_cmd;
        logic in_plane_ok;
        logic word_empty;
        logic count_full;
        logic feat_last;
        logic pad_last;
        logic exp_last;
        logic div_last;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic [9:0]  feature_index;
        logic        is_target;
        logic [16:0] target;
        logic        overflow;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/bpfe_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bpfe_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [63:0]        board_word;
    logic [3:0]         plane_index;
    logic signed [31:0] score;
    logic signed [1:0]  outcome;

    modport source (output valid, cmd, board_word, plane_index, score, outcome,
                    input ready);
    modport sink   (input valid, cmd, board_word, plane_index, score, outcome,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/bpfe_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bpfe_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  feature_index;
    logic        is_target;
    logic [16:0] target;
    logic        overflow;
    logic        last;

    modport source (output valid, feature_index, is_target, target, overflow, last,
                    input ready);
    modport sink   (input valid, feature_index, is_target, target, overflow, last,
                    output ready);
endinterface

`default_nettype wire

FILE: hdl/bpfe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bpfe_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire bpfe_pkg::t_dp_sts i_sts,
    output bpfe_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_PCNT, S_FEAT, S_EXP, S_DIV_INIT, S_DIV,
        S_MIX1, S_MIX2, S_PAD, S_TGT
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // command decode and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_cmd == bpfe_pkg::CMD_END) begin
                        n_state = S_EXP;
                    end else if (i_sts.in_plane_ok) begin
                        n_state = S_PCNT;
                    end
                end
            end
            S_PCNT: begin
                o_cmd.pcnt = 1'b1;
                n_state = (i_sts.word_empty || i_sts.count_full) ? S_IDLE : S_FEAT;
            end
            S_FEAT: begin
                if (i_sts.out_free) begin
                    o_cmd.feat = 1'b1;
                    if (i_sts.feat_last) n_state = S_IDLE;
                end
            end
            S_EXP: begin
                o_cmd.exp_step = 1'b1;
                if (i_sts.exp_last) n_state = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_MIX1;
            end
            S_MIX1: begin
                o_cmd.mix1 = 1'b1;
                n_state = S_MIX2;
            end
            S_MIX2: begin
                o_cmd.mix2 = 1'b1;
                n_state = i_sts.count_full ? S_TGT : S_PAD;
            end
            S_PAD: begin
                if (i_sts.out_free) begin
                    o_cmd.pad = 1'b1;
                    if (i_sts.pad_last) n_state = S_TGT;
                end
            end
            S_TGT: begin
                if (i_sts.out_free) begin
                    o_cmd.tgt = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // emit commands only when the output register can take a beat
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.feat || o_cmd.pad || o_cmd.tgt) |-> i_sts.out_free)
        else $error("emit without free output register");
    // an end item always closes with the target beat
    a_pad_to_tgt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.pad && i_sts.pad_last) |=> (r_state == S_TGT))
        else $error("padding did not lead to target");
    // loading happens only on an accepted beat
    a_load_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (i_in_valid && r_state == S_IDLE))
        else $error("load without accept");

endmodule

`default_nettype wire

FILE: hdl/bpfe_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bpfe_dp #(
    parameter int MAX_FEATURES = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bpfe_pkg::t_dp_cmd  i_cmd,
    output bpfe_pkg::t_dp_sts       o_sts,
    input  wire logic [16:0]        i_blend,
    input  wire logic               i_cmd_bit,
    input  wire logic [63:0]        i_board_word,
    input  wire logic [3:0]         i_plane_index,
    input  wire logic signed [31:0] i_score,
    input  wire logic [1:0]         i_outcome,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output bpfe_pkg::t_result       o_out
);

    localparam int CW = $clog2(MAX_FEATURES + 1);

    logic [63:0]    r_word;
    logic [3:0]     r_plane;
    logic [1:0]     r_oc;
    logic [CW-1:0]  r_count;
    logic           r_ovf;
    logic [12:0]    r_a;
    logic           r_neg;
    logic [32:0]    r_e;
    logic [31:0]    r_p;
    logic [4:0]     r_step;
    logic [33:0]    r_d;
    logic [33:0]    r_rem;
    logic [16:0]    r_nlo;
    logic [16:0]    r_q;
    logic [33:0]    r_prod;
    logic [16:0]    r_tgt;
    logic           r_out_valid;
    bpfe_pkg::t_result r_out;

    logic [6:0]     w_pop;
    logic [5:0]     w_sq;
    logic [63:0]    w_word_next;
    logic [12:0]    w_a;
    logic [64:0]    w_e_prod;
    logic [63:0]    w_p_prod;
    logic [33:0]    w_d;
    logic [48:0]    w_num;
    logic [34:0]    w_trial;
    logic [16:0]    w_b;
    logic [16:0]    w_wdl;
    logic [34:0]    w_sum;
    logic [34:0]    w_res_term;
    logic           w_out_free;

    // population count and lowest set square
    always_comb begin
        w_pop = '0;
        w_sq  = '0;
        for (int k = 0; k < 64; k++) begin
            w_pop = w_pop + 7'(r_word[k]);
        end
        for (int k = 63; k >= 0; k--) begin
            if (r_word[k]) w_sq = 6'(k);
        end
    end
    assign w_word_next = r_word & (r_word - 64'd1);

    // clamped score magnitude
    always_comb begin
        if (i_score > 32'(bpfe_pkg::SCORE_LIMIT) ||
            i_score < -32'(bpfe_pkg::SCORE_LIMIT)) begin
            w_a = 13'(bpfe_pkg::SCORE_LIMIT);
        end else if (i_score[31]) begin
            w_a = 13'(-i_score);
        end else begin
            w_a = i_score[12:0];
        end
    end

    // exp step products
    assign w_e_prod = 65'(r_e) * 65'(r_p) + 65'(64'h8000_0000);
    assign w_p_prod = 64'(r_p) * 64'(r_p) + 64'h8000_0000;

    // divider setup and trial subtract
    assign w_d     = 34'h1_0000_0000 + 34'(r_e);
    assign w_num   = 49'h1_0000_0000_0000 + 49'(w_d >> 1);
    assign w_trial = {r_rem, r_nlo[16]};

    // blend arithmetic
    assign w_b   = (i_blend > bpfe_pkg::ONE_Q16) ? bpfe_pkg::ONE_Q16 : i_blend;
    assign w_wdl = r_neg ? (bpfe_pkg::ONE_Q16 - r_q) : r_q;
    always_comb begin
        case (r_oc)
            bpfe_pkg::OC_WIN:  w_res_term = {2'b0, w_b, 16'b0};
            bpfe_pkg::OC_DRAW: w_res_term = {3'b0, w_b, 15'b0};
            default:           w_res_term = '0;
        endcase
    end
    assign w_sum = 35'(r_prod) + w_res_term + 35'd32768;

    assign w_out_free = !r_out_valid || i_out_ready;

    // status
    always_comb begin
        o_sts.in_cmd      = i_cmd_bit;
        o_sts.in_plane_ok = (i_plane_index < 4'(bpfe_pkg::NUM_PLANES));
        o_sts.word_empty  = (r_word == 64'd0);
        o_sts.count_full  = (r_count == CW'(MAX_FEATURES));
        o_sts.feat_last   = (w_word_next == 64'd0) ||
                            (r_count + CW'(1) == CW'(MAX_FEATURES));
        o_sts.pad_last    = (r_count + CW'(1) == CW'(MAX_FEATURES));
        o_sts.exp_last    = (r_step == 5'(bpfe_pkg::EXP_STEPS - 1));
        o_sts.div_last    = (r_step == 5'(bpfe_pkg::QUOT_BITS - 1));
        o_sts.out_free    = w_out_free;
    end

    // record state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.pcnt) begin
                if ({1'b0, w_pop} > (8'(MAX_FEATURES) - 8'(r_count))) r_ovf <= 1'b1;
            end
            if (i_cmd.feat || i_cmd.pad) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.tgt) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    // item payload, exp loop and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word  <= i_board_word;
            r_plane <= i_plane_index;
            r_oc    <= i_outcome;
            r_a     <= w_a;
            r_neg   <= i_score[31];
            r_e     <= 33'h1_0000_0000;
            r_p     <= bpfe_pkg::EXP_STEP_Q32;
            r_step  <= '0;
        end
        if (i_cmd.feat) begin
            r_word <= w_word_next;
        end
        if (i_cmd.exp_step) begin
            if (r_a[r_step[3:0]]) r_e <= w_e_prod[64:32];
            r_p    <= w_p_prod[63:32];
            r_step <= r_step + 5'd1;
        end
        if (i_cmd.div_init) begin
            r_d    <= w_d;
            r_rem  <= 34'(w_num[48:17]);
            r_nlo  <= w_num[16:0];
            r_q    <= '0;
            r_step <= '0;
        end
        if (i_cmd.div_step) begin
            if (w_trial >= 35'(r_d)) begin
                r_rem <= 34'(w_trial - 35'(r_d));
                r_q   <= {r_q[15:0], 1'b1};
            end else begin
                r_rem <= w_trial[33:0];
                r_q   <= {r_q[15:0], 1'b0};
            end
            r_nlo  <= {r_nlo[15:0], 1'b0};
            r_step <= r_step + 5'd1;
        end
        if (i_cmd.mix1) begin
            r_prod <= 34'(bpfe_pkg::ONE_Q16 - w_b) * 34'(w_wdl);
        end
        if (i_cmd.mix2) begin
            r_tgt <= w_sum[32:16];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.feat || i_cmd.pad || i_cmd.tgt) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.feat) begin
            r_out.feature_index <= {r_plane, w_sq};
            r_out.is_target     <= 1'b0;
            r_out.target        <= '0;
            r_out.overflow      <= r_ovf;
            r_out.last          <= o_sts.feat_last;
        end else if (i_cmd.pad) begin
            r_out.feature_index <= bpfe_pkg::PAD_INDEX;
            r_out.is_target     <= 1'b0;
            r_out.target        <= '0;
            r_out.overflow      <= r_ovf;
            r_out.last          <= 1'b0;
        end else if (i_cmd.tgt) begin
            r_out.feature_index <= '0;
            r_out.is_target     <= 1'b1;
            r_out.target        <= r_tgt;
            r_out.overflow      <= r_ovf;
            r_out.last          <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // feature count never passes the limit
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_FEATURES))
        else $error("feature count past limit");
    // target beats carry index zero and a target in range
    a_tgt_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.is_target) |->
        (r_out.feature_index == 10'd0 && r_out.target <= bpfe_pkg::ONE_Q16 && r_out.last))
        else $error("bad target beat");
    // the target beat closes the record
    a_tgt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tgt |=> (r_count == '0 && !r_ovf))
        else $error("record not cleared");

endmodule

`default_nettype wire

FILE: hdl/board_plane_feature_encoder.sv
// Board plane feature encoder. Plane beats (cmd 0) give one feature index
// plane*64+square per set bit, lowest square first, up to MAX_FEATURES per
// record; extra bits are dropped and flag overflow on every beat of the item.
// Planes above 11 are ignored. An end beat (cmd 1) pads the record with index
// 768 up to MAX_FEATURES, then sends one target beat in q1.16 blending the
// score-derived win probability with the outcome by the blend register
// (write with i_cfg_we only while idle). A plane item is loaded and counted,
// then sends one beat per kept bit; an ignored plane is only loaded. An end
// item runs the 13-step exp loop on a shared multiplier pair and the 17-step
// serial divider before its pad beats. One result beat per cycle out; output
// stalls hold.
`timescale 1ns / 1ps
`default_nettype none

module board_plane_feature_encoder #(
    parameter int MAX_FEATURES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bpfe_in_if.sink          i_in,
    bpfe_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [16:0] i_cfg_data
);

    logic [16:0]         r_blend;
    bpfe_pkg::t_dp_cmd   w_cmd;
    bpfe_pkg::t_dp_sts   w_sts;
    bpfe_pkg::t_result   w_res;
    logic                w_out_valid;

    // blend register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend <= '0;
        end else if (i_cfg_we) begin
            r_blend <= i_cfg_data;
        end
    end

    bpfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bpfe_dp #(
        .MAX_FEATURES (MAX_FEATURES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_blend       (r_blend),
        .i_cmd_bit     (i_in.cmd),
        .i_board_word  (i_in.board_word),
        .i_plane_index (i_in.plane_index),
        .i_score       (i_in.score),
        .i_outcome     (i_in.outcome),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (w_out_valid),
        .o_out         (w_res)
    );

    assign o_out.valid         = w_out_valid;
    assign o_out.feature_index = w_res.feature_index;
    assign o_out.is_target     = w_res.is_target;
    assign o_out.target        = w_res.target;
    assign o_out.overflow      = w_res.overflow;
    assign o_out.last          = w_res.last;

endmodule

`default_nettype wire
